// ----- hw/rtl/bprd_pkg.sv -----
// ----------------------------------------------------------------------------
// bprd_pkg
// Shared constants and types of the button press RGB dimmer.
// ----------------------------------------------------------------------------
package bprd_pkg;

    localparam int LINE_W   = 4;
    localparam int TIME_W   = 32;
    localparam int MS_W     = 16;
    localparam int DUTY_W   = 7;
    localparam int COLOR_W  = 2;
    localparam int KIND_W   = 3;
    localparam int CIDX_W   = 3;
    localparam int CDATA_W  = 16;
    localparam int IN_W     = 40;   // line + time, padded to bytes
    localparam int OUT_W    = 24;   // color + three duties, padded to bytes

    // event kinds
    localparam logic [KIND_W-1:0] KIND_OTHER  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_BOUNCE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PRESS  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SHORT  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_LONG   = 3'd4;

    // colors
    localparam logic [COLOR_W-1:0] COLOR_RED   = 2'd0;
    localparam logic [COLOR_W-1:0] COLOR_GREEN = 2'd1;
    localparam logic [COLOR_W-1:0] COLOR_BLUE  = 2'd2;

    // register indexes
    localparam logic [CIDX_W-1:0] REG_BUTTON_LINE   = 3'd0;
    localparam logic [CIDX_W-1:0] REG_DEBOUNCE_MS   = 3'd1;
    localparam logic [CIDX_W-1:0] REG_LONG_PRESS_MS = 3'd2;
    localparam logic [CIDX_W-1:0] REG_DUTY_STEP     = 3'd3;
    localparam logic [CIDX_W-1:0] REG_DUTY_MAX      = 3'd4;

    // reset values
    localparam logic [LINE_W-1:0] RST_BUTTON_LINE   = 4'd11;
    localparam logic [MS_W-1:0]   RST_DEBOUNCE_MS   = 16'd50;
    localparam logic [MS_W-1:0]   RST_LONG_PRESS_MS = 16'd600;
    localparam logic [DUTY_W-1:0] RST_DUTY_STEP     = 7'd10;
    localparam logic [DUTY_W-1:0] RST_DUTY_MAX      = 7'd100;
    localparam logic [DUTY_W-1:0] RST_LEVEL         = 7'd100;

    typedef struct packed {
        logic [LINE_W-1:0] button_line;
        logic [MS_W-1:0]   debounce_ms;
        logic [MS_W-1:0]   long_press_ms;
        logic [DUTY_W-1:0] duty_step;
        logic [DUTY_W-1:0] duty_max;
    } t_cfg;

    typedef struct packed {
        logic [KIND_W-1:0]  event_kind;
        logic [COLOR_W-1:0] selected_color;
        logic [DUTY_W-1:0]  red_duty;
        logic [DUTY_W-1:0]  green_duty;
        logic [DUTY_W-1:0]  blue_duty;
    } t_result;

endpackage

// ----- hw/rtl/bprd_core.sv -----
// ----------------------------------------------------------------------------
// bprd_core
// Button state: debounce, press tracking, color select and duty ramp.
// ----------------------------------------------------------------------------
module bprd_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [bprd_pkg::LINE_W-1:0]   i_line_number,
    input  logic [bprd_pkg::TIME_W-1:0]   i_time_ms,
    input  bprd_pkg::t_cfg                i_cfg,
    output bprd_pkg::t_result             o_result
);

    logic                            r_press_active, n_press_active;
    logic [bprd_pkg::TIME_W-1:0]     r_press_start, n_press_start;
    logic [bprd_pkg::TIME_W-1:0]     r_last_accept, n_last_accept;
    logic [bprd_pkg::COLOR_W-1:0]    r_select_count, n_select_count;
    logic [bprd_pkg::COLOR_W-1:0]    r_color, n_color;
    logic [bprd_pkg::DUTY_W-1:0]     r_red, n_red;
    logic [bprd_pkg::DUTY_W-1:0]     r_green, n_green;
    logic [bprd_pkg::DUTY_W-1:0]     r_blue, n_blue;
    logic                            r_ramp_up, n_ramp_up;
    logic [bprd_pkg::KIND_W-1:0]     kind;

    logic [bprd_pkg::TIME_W-1:0]     since_last;
    logic [bprd_pkg::TIME_W-1:0]     press_len;
    logic [bprd_pkg::DUTY_W-1:0]     cur_level;
    logic [bprd_pkg::DUTY_W:0]       up_sum;
    logic [bprd_pkg::DUTY_W-1:0]     ramp_level;
    logic                            ramp_dir;

    assign since_last = i_time_ms - r_last_accept;
    assign press_len  = i_time_ms - r_press_start;

    always_comb begin
        case (r_color)
            bprd_pkg::COLOR_RED:   cur_level = r_red;
            bprd_pkg::COLOR_GREEN: cur_level = r_green;
            default:               cur_level = r_blue;
        endcase
    end

    // shared triangle ramp; down test is level - step > 0, i.e. level > step
    assign up_sum = {1'b0, cur_level} + {1'b0, i_cfg.duty_step};

    always_comb begin
        if (r_ramp_up) begin
            if (up_sum < {1'b0, i_cfg.duty_max}) begin
                ramp_level = up_sum[bprd_pkg::DUTY_W-1:0];
                ramp_dir   = 1'b1;
            end else begin
                ramp_level = i_cfg.duty_max;
                ramp_dir   = 1'b0;
            end
        end else begin
            if (cur_level > i_cfg.duty_step) begin
                ramp_level = cur_level - i_cfg.duty_step;
                ramp_dir   = 1'b0;
            end else begin
                ramp_level = '0;
                ramp_dir   = 1'b1;
            end
        end
    end

    always_comb begin
        n_press_active = r_press_active;
        n_press_start  = r_press_start;
        n_last_accept  = r_last_accept;
        n_select_count = r_select_count;
        n_color        = r_color;
        n_red          = r_red;
        n_green        = r_green;
        n_blue         = r_blue;
        n_ramp_up      = r_ramp_up;

        if (i_line_number != i_cfg.button_line) begin
            kind = bprd_pkg::KIND_OTHER;
        end else if (since_last < {{(bprd_pkg::TIME_W-bprd_pkg::MS_W){1'b0}},
                                   i_cfg.debounce_ms}) begin
            kind = bprd_pkg::KIND_BOUNCE;
        end else begin
            n_last_accept = i_time_ms;
            if (!r_press_active) begin
                kind           = bprd_pkg::KIND_PRESS;
                n_press_active = 1'b1;
                n_press_start  = i_time_ms;
            end else begin
                n_press_active = 1'b0;
                if (press_len <= {{(bprd_pkg::TIME_W-bprd_pkg::MS_W){1'b0}},
                                  i_cfg.long_press_ms}) begin
                    kind = bprd_pkg::KIND_SHORT;
                    case (r_select_count)
                        2'd1: begin
                            n_color        = bprd_pkg::COLOR_GREEN;
                            n_select_count = 2'd2;
                        end
                        2'd2: begin
                            n_color        = bprd_pkg::COLOR_BLUE;
                            n_select_count = 2'd0;
                        end
                        default: begin
                            n_color        = bprd_pkg::COLOR_RED;
                            n_select_count = 2'd1;
                        end
                    endcase
                end else begin
                    kind = bprd_pkg::KIND_LONG;
                    // an out-of-range choice leaves levels and ramp alone
                    case (r_color)
                        bprd_pkg::COLOR_RED: begin
                            n_red     = ramp_level;
                            n_ramp_up = ramp_dir;
                        end
                        bprd_pkg::COLOR_GREEN: begin
                            n_green   = ramp_level;
                            n_ramp_up = ramp_dir;
                        end
                        bprd_pkg::COLOR_BLUE: begin
                            n_blue    = ramp_level;
                            n_ramp_up = ramp_dir;
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_active <= 1'b0;
            r_press_start  <= '0;
            r_last_accept  <= '0;
            r_select_count <= '0;
            r_color        <= bprd_pkg::COLOR_RED;
            r_red          <= bprd_pkg::RST_LEVEL;
            r_green        <= bprd_pkg::RST_LEVEL;
            r_blue         <= bprd_pkg::RST_LEVEL;
            r_ramp_up      <= 1'b1;
        end else if (i_en) begin
            r_press_active <= n_press_active;
            r_press_start  <= n_press_start;
            r_last_accept  <= n_last_accept;
            r_select_count <= n_select_count;
            r_color        <= n_color;
            r_red          <= n_red;
            r_green        <= n_green;
            r_blue         <= n_blue;
            r_ramp_up      <= n_ramp_up;
        end
    end

    // results carry the state after the event
    assign o_result.event_kind     = kind;
    assign o_result.selected_color = n_color;
    assign o_result.red_duty       = n_red;
    assign o_result.green_duty     = n_green;
    assign o_result.blue_duty      = n_blue;

endmodule

// ----- hw/rtl/button_press_rgb_dimmer_unit.sv -----
// ----------------------------------------------------------------------------
// button_press_rgb_dimmer_unit
// Debounced button edge events drive color select and duty dimming.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                    | payload
//  ----------+-----------+------------------------------+----------------------
//  s_axis    | in        | s_axis_tvalid/s_axis_tready  | line, time_ms
//  m_axis    | out       | m_axis_tvalid/m_axis_tready  | kind, color, duties
//  cfg       | in        | i_cfg_valid/o_cfg_ready      | index, data
//
//  One word per cycle sustained while m_axis_tready is high; a word passes the
//  input register, then the result register. The bprd_core state update sets the rate.
//  Synchronous active-low reset restores register defaults and button state.
//  The input register keeps accepting while the result register holds a word,
//  so a stalled output costs no bubble until both stages are full.
//  Config is always ready.
// ----------------------------------------------------------------------------
module button_press_rgb_dimmer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [3:0] line_number, [35:4] time_ms, [39:36] zero
    input  logic [bprd_pkg::IN_W-1:0]     s_axis_tdata,

    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [1:0] selected_color, [8:2] red_duty, [15:9] green_duty,
    // [22:16] blue_duty, [23] zero
    output logic [bprd_pkg::OUT_W-1:0]    m_axis_tdata,
    // [2:0] event_kind
    output logic [bprd_pkg::KIND_W-1:0]   m_axis_tuser,

    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bprd_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic [bprd_pkg::CDATA_W-1:0]  i_cfg_data
);

    bprd_pkg::t_cfg     r_cfg;
    bprd_pkg::t_result  core_result;
    bprd_pkg::t_result  r_out;

    logic                            r_in_valid;
    logic [bprd_pkg::LINE_W-1:0]     r_in_line;
    logic [bprd_pkg::TIME_W-1:0]     r_in_time;
    logic                            r_out_valid;
    logic                            out_free;
    logic                            advance;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.button_line   <= bprd_pkg::RST_BUTTON_LINE;
            r_cfg.debounce_ms   <= bprd_pkg::RST_DEBOUNCE_MS;
            r_cfg.long_press_ms <= bprd_pkg::RST_LONG_PRESS_MS;
            r_cfg.duty_step     <= bprd_pkg::RST_DUTY_STEP;
            r_cfg.duty_max      <= bprd_pkg::RST_DUTY_MAX;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bprd_pkg::REG_BUTTON_LINE:
                    r_cfg.button_line <= i_cfg_data[bprd_pkg::LINE_W-1:0];
                bprd_pkg::REG_DEBOUNCE_MS:
                    r_cfg.debounce_ms <= i_cfg_data[bprd_pkg::MS_W-1:0];
                bprd_pkg::REG_LONG_PRESS_MS:
                    r_cfg.long_press_ms <= i_cfg_data[bprd_pkg::MS_W-1:0];
                bprd_pkg::REG_DUTY_STEP:
                    r_cfg.duty_step <= i_cfg_data[bprd_pkg::DUTY_W-1:0];
                bprd_pkg::REG_DUTY_MAX:
                    r_cfg.duty_max <= i_cfg_data[bprd_pkg::DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_line <= s_axis_tdata[bprd_pkg::LINE_W-1:0];
            r_in_time <= s_axis_tdata[bprd_pkg::LINE_W +: bprd_pkg::TIME_W];
        end
    end

    bprd_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (advance),
        .i_line_number (r_in_line),
        .i_time_ms     (r_in_time),
        .i_cfg         (r_cfg),
        .o_result      (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.event_kind;
    assign m_axis_tdata  = {1'b0, r_out.blue_duty, r_out.green_duty,
                            r_out.red_duty, r_out.selected_color};

endmodule

// ----- test/button_press_rgb_dimmer_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// button_press_rgb_dimmer_unit_test
// Streams button edge words into the dimmer and checks every result word
// (event kind, selected color, three duties) against a behavioral predictor
// of the debounce, press/release and triangle-ramp logic. The run goes
// through several register settings with random idling on both streams.
// ----------------------------------------------------------------------------
module button_press_rgb_dimmer_unit_test;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 4;
    localparam int PHASES        = 8;
    localparam int EDGES_PER_SET = 147;

    logic                               i_clk          = 1'b0;
    logic                               i_rst_n        = 1'b0;
    logic                               s_axis_tvalid  = 1'b0;
    logic                               s_axis_tready;
    logic [bprd_pkg::IN_W-1:0]          s_axis_tdata   = '0;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready  = 1'b0;
    logic [bprd_pkg::OUT_W-1:0]         m_axis_tdata;
    logic [bprd_pkg::KIND_W-1:0]        m_axis_tuser;
    logic                               i_cfg_valid    = 1'b0;
    logic                               o_cfg_ready;
    logic [bprd_pkg::CIDX_W-1:0]        i_cfg_index    = '0;
    logic [bprd_pkg::CDATA_W-1:0]       i_cfg_data     = '0;

    button_press_rgb_dimmer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // stimulus and scoreboard
    logic [bprd_pkg::IN_W-1:0]   pending_edges[$];
    bprd_pkg::t_result           expected_dimmer_states[$];
    int                          send_idle_pct  = 0;
    int                          recv_stall_pct = 0;
    logic                        in_fire        = 1'b0;
    int                          cycle_count    = 0;
    int                          error_count    = 0;
    int                          words_checked  = 0;
    int                          kind_count[5]  = '{default: 0};
    logic [bprd_pkg::TIME_W-1:0] clock_ms       = '0;

    // predictor state
    bprd_pkg::t_cfg               model_cfg;
    logic                         pressed;
    logic [bprd_pkg::TIME_W-1:0]  press_start_ms;
    logic [bprd_pkg::TIME_W-1:0]  last_edge_ms;
    logic [1:0]                   cycle_pos;
    logic [bprd_pkg::COLOR_W-1:0] chosen_color;
    logic [bprd_pkg::DUTY_W-1:0]  duty_level[3];
    logic                         ramp_rising;

    function automatic bprd_pkg::t_result dimmer_after_edge(
            input logic [bprd_pkg::LINE_W-1:0] line,
            input logic [bprd_pkg::TIME_W-1:0] now);
        bprd_pkg::t_result           res;
        logic [bprd_pkg::TIME_W-1:0] since_last;
        logic [bprd_pkg::TIME_W-1:0] held_ms;
        int                          lvl;
        int                          step_sz;
        int                          top;
        since_last = now - last_edge_ms;
        held_ms    = now - press_start_ms;
        step_sz    = int'(model_cfg.duty_step);
        top        = int'(model_cfg.duty_max);
        if (line != model_cfg.button_line) begin
            res.event_kind = bprd_pkg::KIND_OTHER;
        end else if (since_last < {16'b0, model_cfg.debounce_ms}) begin
            res.event_kind = bprd_pkg::KIND_BOUNCE;
        end else begin
            if (!pressed) begin
                pressed        = 1'b1;
                press_start_ms = now;
                res.event_kind = bprd_pkg::KIND_PRESS;
            end else begin
                pressed = 1'b0;
                if (held_ms <= {16'b0, model_cfg.long_press_ms}) begin
                    res.event_kind = bprd_pkg::KIND_SHORT;
                    case (cycle_pos)
                        2'd1: begin
                            chosen_color = bprd_pkg::COLOR_GREEN;
                            cycle_pos    = 2'd2;
                        end
                        2'd2: begin
                            chosen_color = bprd_pkg::COLOR_BLUE;
                            cycle_pos    = 2'd0;
                        end
                        default: begin
                            chosen_color = bprd_pkg::COLOR_RED;
                            cycle_pos    = 2'd1;
                        end
                    endcase
                end else begin
                    res.event_kind = bprd_pkg::KIND_LONG;
                    if (chosen_color <= bprd_pkg::COLOR_BLUE) begin
                        lvl = int'(duty_level[chosen_color]);
                        // signed compares so a step past zero clamps instead of wrapping
                        if (ramp_rising) begin
                            if (lvl + step_sz < top) begin
                                lvl = lvl + step_sz;
                            end else begin
                                lvl         = top;
                                ramp_rising = 1'b0;
                            end
                        end else begin
                            if (lvl - step_sz > 0) begin
                                lvl = lvl - step_sz;
                            end else begin
                                lvl         = 0;
                                ramp_rising = 1'b1;
                            end
                        end
                        duty_level[chosen_color] = lvl[bprd_pkg::DUTY_W-1:0];
                    end
                end
            end
            last_edge_ms = now;
        end
        res.selected_color = chosen_color;
        res.red_duty       = duty_level[0];
        res.green_duty     = duty_level[1];
        res.blue_duty      = duty_level[2];
        return res;
    endfunction

    function automatic void check_field(input string name, input int exp_val,
                                        input int act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val,
                     act_val);
            error_count++;
        end
    endfunction

    // drive on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if (!s_axis_tvalid || in_fire) begin
                if (pending_edges.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_edges.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // sample on the rising edge: predict accepted words, check result words
    always @(posedge i_clk) begin
        bprd_pkg::t_result exp_res;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_dimmer_states.size());
            $display("[button_press_rgb_dimmer_unit] ERROR");
            $finish;
        end
        in_fire <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (!i_rst_n) begin
            model_cfg.button_line   = bprd_pkg::RST_BUTTON_LINE;
            model_cfg.debounce_ms   = bprd_pkg::RST_DEBOUNCE_MS;
            model_cfg.long_press_ms = bprd_pkg::RST_LONG_PRESS_MS;
            model_cfg.duty_step     = bprd_pkg::RST_DUTY_STEP;
            model_cfg.duty_max      = bprd_pkg::RST_DUTY_MAX;
            pressed        = 1'b0;
            press_start_ms = '0;
            last_edge_ms   = '0;
            cycle_pos      = 2'd0;
            chosen_color   = bprd_pkg::COLOR_RED;
            duty_level     = '{bprd_pkg::RST_LEVEL, bprd_pkg::RST_LEVEL,
                               bprd_pkg::RST_LEVEL};
            ramp_rising    = 1'b1;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    bprd_pkg::REG_BUTTON_LINE:
                        model_cfg.button_line = i_cfg_data[bprd_pkg::LINE_W-1:0];
                    bprd_pkg::REG_DEBOUNCE_MS:
                        model_cfg.debounce_ms = i_cfg_data;
                    bprd_pkg::REG_LONG_PRESS_MS:
                        model_cfg.long_press_ms = i_cfg_data;
                    bprd_pkg::REG_DUTY_STEP:
                        model_cfg.duty_step = i_cfg_data[bprd_pkg::DUTY_W-1:0];
                    bprd_pkg::REG_DUTY_MAX:
                        model_cfg.duty_max = i_cfg_data[bprd_pkg::DUTY_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                exp_res = dimmer_after_edge(s_axis_tdata[bprd_pkg::LINE_W-1:0],
                                            s_axis_tdata[bprd_pkg::LINE_W +: bprd_pkg::TIME_W]);
                kind_count[exp_res.event_kind]++;
                expected_dimmer_states.push_back(exp_res);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_dimmer_states.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, got %h/%h", $time,
                             m_axis_tuser, m_axis_tdata);
                    error_count++;
                end else begin
                    exp_res = expected_dimmer_states.pop_front();
                    words_checked++;
                    check_field("event_kind", int'(exp_res.event_kind), int'(m_axis_tuser));
                    check_field("selected_color", int'(exp_res.selected_color),
                                int'(m_axis_tdata[1:0]));
                    check_field("red_duty", int'(exp_res.red_duty),
                                int'(m_axis_tdata[8:2]));
                    check_field("green_duty", int'(exp_res.green_duty),
                                int'(m_axis_tdata[15:9]));
                    check_field("blue_duty", int'(exp_res.blue_duty),
                                int'(m_axis_tdata[22:16]));
                end
            end
        end
    end

    task automatic queue_edge(input logic [bprd_pkg::LINE_W-1:0] line,
                              input logic [bprd_pkg::TIME_W-1:0] ms);
        pending_edges.push_back({{(bprd_pkg::IN_W - bprd_pkg::LINE_W - bprd_pkg::TIME_W){1'b0}},
                                 ms, line});
    endtask

    task automatic write_reg(input logic [bprd_pkg::CIDX_W-1:0] idx,
                             input logic [bprd_pkg::CDATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic apply_setting(input logic [bprd_pkg::LINE_W-1:0] line,
                                 input logic [bprd_pkg::MS_W-1:0] deb,
                                 input logic [bprd_pkg::MS_W-1:0] hold,
                                 input logic [bprd_pkg::DUTY_W-1:0] step,
                                 input logic [bprd_pkg::DUTY_W-1:0] top);
        write_reg(bprd_pkg::REG_BUTTON_LINE, bprd_pkg::CDATA_W'(line));
        write_reg(bprd_pkg::REG_DEBOUNCE_MS, deb);
        write_reg(bprd_pkg::REG_LONG_PRESS_MS, hold);
        write_reg(bprd_pkg::REG_DUTY_STEP, bprd_pkg::CDATA_W'(step));
        write_reg(bprd_pkg::REG_DUTY_MAX, bprd_pkg::CDATA_W'(top));
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_edges.size() != 0 || s_axis_tvalid ||
               expected_dimmer_states.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // mostly press/release pairs of chosen length, plus bounces, other lines and wraps
    task automatic queue_presses(input int count);
        int                          pick;
        int                          deb;
        int                          hold;
        logic [bprd_pkg::TIME_W-1:0] gap;
        deb  = int'(model_cfg.debounce_ms);
        hold = int'(model_cfg.long_press_ms);
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                queue_edge(bprd_pkg::LINE_W'($urandom_range(0, 15)), $urandom);
            end else begin
                if (pick < 22) begin
                    gap = $urandom_range(0, deb);
                end else if (pick < 58) begin
                    gap = $urandom_range(deb, (hold > deb) ? hold : deb);
                end else if (pick < 94) begin
                    gap = ((hold + 1 > deb) ? hold + 1 : deb) + $urandom_range(0, 3000);
                end else begin
                    gap = $urandom;
                end
                clock_ms = clock_ms + gap;
                queue_edge(model_cfg.button_line, clock_ms);
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                wait_drained();
                case (phase)
                    1: apply_setting(4'd0, 16'd0, 16'd0, 7'd1, 7'd1);
                    2: apply_setting(4'd15, 16'hFFFF, 16'hFFFF, 7'd127, 7'd127);
                    3: apply_setting(4'd5, 16'd20, 16'd300, 7'd7, 7'd40);
                    4: apply_setting(bprd_pkg::LINE_W'($urandom_range(0, 15)),
                                     bprd_pkg::MS_W'($urandom_range(0, 200)),
                                     bprd_pkg::MS_W'($urandom_range(0, 1500)),
                                     bprd_pkg::DUTY_W'($urandom_range(1, 40)),
                                     bprd_pkg::DUTY_W'($urandom_range(1, 127)));
                    5: apply_setting(4'd11, 16'd10, 16'd100, 7'd3, 7'd127);
                    6: apply_setting(bprd_pkg::LINE_W'($urandom_range(0, 15)),
                                     bprd_pkg::MS_W'($urandom_range(0, 65535)),
                                     bprd_pkg::MS_W'($urandom_range(0, 65535)),
                                     bprd_pkg::DUTY_W'($urandom_range(1, 127)),
                                     bprd_pkg::DUTY_W'($urandom_range(1, 127)));
                    // lowered ceiling: levels left above it clamp on the next upward step
                    default: apply_setting(4'd10, 16'd5, 16'd50, 7'd4, 7'd10);
                endcase
            end
            case (phase % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 67;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 67;
                end
                default: begin
                    send_idle_pct  = 21;
                    recv_stall_pct = 21;
                end
            endcase
            if (phase == 0) begin
                // reset settings: line 11, debounce 50, long press above 600
                queue_edge(4'd11, 32'd0);           // bounce right after reset
                queue_edge(4'd11, 32'd49);
                queue_edge(4'd3, 32'd60);           // other line
                queue_edge(4'd15, 32'hFFFF_FFFF);
                queue_edge(4'd0, 32'd0);
                queue_edge(4'd11, 32'd50);          // press exactly at debounce
                queue_edge(4'd11, 32'd99);          // bounce while held
                queue_edge(4'd11, 32'd650);         // 600 ms: still short -> red
                queue_edge(4'd11, 32'd700);
                queue_edge(4'd11, 32'd1301);        // 601 ms: long, clamps at max
                queue_edge(4'd11, 32'd1400);
                queue_edge(4'd11, 32'd2100);        // long, ramp now downward
                queue_edge(4'd11, 32'd2200);
                queue_edge(4'd11, 32'd2250);        // short -> green
                queue_edge(4'd11, 32'd2300);
                queue_edge(4'd11, 32'd2301);
                queue_edge(4'd11, 32'd3000);        // long on green
                queue_edge(4'd11, 32'd3100);
                queue_edge(4'd11, 32'd3150);        // short -> blue, selection count wraps
                queue_edge(4'd11, 32'hFFFF_FFF0);
                queue_edge(4'd11, 32'h0000_0100);   // press across tick wrap, short
                queue_edge(4'd11, 32'hFFFF_FFFF);
                queue_edge(4'd11, 32'h0000_0400);   // long across tick wrap
                clock_ms = 32'h0000_0400;
            end
            queue_presses(EDGES_PER_SET);
        end
        wait_drained();

        $display("Checked %0d result words over %0d register settings with stream idling.",
                 words_checked, PHASES);
        $display("Kinds seen: %0d other line, %0d bounce, %0d press, %0d short, %0d long.",
                 kind_count[bprd_pkg::KIND_OTHER], kind_count[bprd_pkg::KIND_BOUNCE],
                 kind_count[bprd_pkg::KIND_PRESS], kind_count[bprd_pkg::KIND_SHORT],
                 kind_count[bprd_pkg::KIND_LONG]);
        if (error_count == 0) begin
            $display("[button_press_rgb_dimmer_unit] OK");
        end else begin
            $display("[button_press_rgb_dimmer_unit] ERROR");
        end
        $finish;
    end

endmodule
